@@ design/vfuo_pkg.sv @@
// ============================================================================
// vfuo_pkg - shared types and constants of the vec3 float unary op unit
// Holds the item structs, the operation codes, the register indexes and the
// IEEE single-precision bit patterns that the datapath uses.
// ============================================================================
package vfuo_pkg;

    // One input item: three IEEE single-precision lanes.
    typedef struct packed {
        logic [31:0] in_x;
        logic [31:0] in_y;
        logic [31:0] in_z;
    } t_in_item;

    // One result item: three lanes plus the error and abort flags.
    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic        error_flag;
        logic        abort_request;
    } t_out_item;

    // Operation codes of the operation_mode register.
    typedef enum logic [2:0] {
        OP_ABS     = 3'd0,
        OP_CEIL    = 3'd1,
        OP_FLOOR   = 3'd2,
        OP_RECIP   = 3'd3,
        OP_NEGATE  = 3'd4,
        OP_ROUND   = 3'd5,
        OP_SIGN    = 3'd6,
        OP_INVALID = 3'd7
    } t_op;

    // Configuration register indexes.
    localparam logic [2:0] CFG_OPERATION_MODE  = 3'd0;
    localparam logic [2:0] CFG_ABORT_ENABLE    = 3'd1;
    localparam logic [2:0] CFG_ERROR_VALUE_X   = 3'd2;
    localparam logic [2:0] CFG_ERROR_VALUE_Y   = 3'd3;
    localparam logic [2:0] CFG_ERROR_VALUE_Z   = 3'd4;
    localparam logic [2:0] CFG_NEAR_ZERO_LIMIT = 3'd5;

    // IEEE single-precision bit patterns.
    localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
    localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
    localparam logic [31:0] ONE_BITS   = 32'h3F80_0000;
    localparam logic [31:0] MONE_BITS  = 32'hBF80_0000;
    localparam logic [31:0] ZERO_BITS  = 32'h0000_0000;
    localparam logic [30:0] INF_MAG    = 31'h7F80_0000;
    localparam logic [31:0] BELOW_HALF = 32'h3EFF_FFFF;
    localparam logic [31:0] LIMIT_RST  = 32'h38D1_B717;

endpackage

@@ design/vec3_float_unary_op_unit_core.sv @@
// ============================================================================
// vec3_float_unary_op_unit_core - three-lane IEEE single unary math pipeline
// Applies abs, ceil, floor, reciprocal, negate, round or sign to each lane
// of a vector, with a near-zero guard on reciprocal and an error vector.
// ============================================================================
// The unit takes one item per clock cycle while the output side does not
// stall, and returns one result item per item, in order. The pipeline depth
// is set by the reciprocal: a restoring divider forms a 27-bit quotient
// at three bits per stage over nine stages, framed by an input register,
// a decode stage and an output register. Every stage has its own valid bit
// and each stage moves forward whenever the one after it is empty or
// moving, so bubbles close up and an item is accepted while a finished
// result still waits at the output. The configuration registers are read
// live by the decode and output stages, so they must only be written while
// no item is in flight.
module vec3_float_unary_op_unit_core
    import vfuo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Nine divider stages of three quotient bits each, after one decode stage.
    localparam int unsigned DIV_STAGES = 9;
    localparam int unsigned DIV_STEPS  = 3;
    localparam int unsigned NUM_STAGES = DIV_STAGES + 1;

    // Per-lane state that travels down the pipeline. A lane whose result is
    // already known carries it in res with use_res set; a reciprocal lane
    // carries the normalized divisor, its exponent and the partial quotient.
    typedef struct packed {
        logic [31:0]        res;
        logic               use_res;
        logic               sgn;
        logic signed [9:0]  ex;
        logic [23:0]        m;
        logic [23:0]        rem;
        logic [26:0]        q;
    } t_lane;

    typedef struct packed {
        t_lane [2:0] lane;
        logic        err;
    } t_stage;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    t_op         r_op;
    logic        r_abort_en;
    logic [31:0] r_err_x;
    logic [31:0] r_err_y;
    logic [31:0] r_err_z;
    logic [31:0] r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op       <= OP_ABS;
            r_abort_en <= 1'b0;
            r_err_x    <= ZERO_BITS;
            r_err_y    <= ZERO_BITS;
            r_err_z    <= ZERO_BITS;
            r_limit    <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OPERATION_MODE:  r_op       <= t_op'(i_cfg_data[2:0]);
                CFG_ABORT_ENABLE:    r_abort_en <= i_cfg_data[0];
                CFG_ERROR_VALUE_X:   r_err_x    <= i_cfg_data;
                CFG_ERROR_VALUE_Y:   r_err_y    <= i_cfg_data;
                CFG_ERROR_VALUE_Z:   r_err_z    <= i_cfg_data;
                CFG_NEAR_ZERO_LIMIT: r_limit    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Lane arithmetic
    // ------------------------------------------------------------------------
    function automatic logic f_is_nan(input logic [31:0] b);
        return b[30:0] > INF_MAG;
    endfunction

    // Negative only for x < 0, so minus zero and NaN count as non-negative.
    function automatic logic f_is_neg(input logic [31:0] b);
        return b[31] && !f_is_nan(b) && (b[30:0] != 31'd0);
    endfunction

    // Floor (up clear) or ceil (up set) to an integer value.
    function automatic logic [31:0] f_round_int(input logic [31:0] b, input logic up);
        logic [7:0]  e;
        logic [4:0]  sh;
        logic [31:0] mask;
        logic [31:0] r;
        e    = b[30:23];
        sh   = 5'd0;
        mask = 32'd0;
        r    = b;
        if (f_is_nan(b)) begin
            r = b | QUIET_BIT;
        end else if (e >= 8'd150) begin
            r = b;
        end else if (e < 8'd127) begin
            if (b[30:0] == 31'd0) begin
                r = b;
            end else if (up) begin
                r = b[31] ? SIGN_BIT : ONE_BITS;
            end else begin
                r = b[31] ? MONE_BITS : ZERO_BITS;
            end
        end else begin
            sh   = 5'(8'd150 - e);
            mask = (32'd1 << sh) - 32'd1;
            if ((b & mask) != 32'd0) begin
                r = ((b[31] != up) ? (b + mask + 32'd1) : b) & ~mask;
            end
        end
        return r;
    endfunction

    // floor(x + 0.5) where the addition rounds to nearest even in single
    // precision. The sum is exact except for the cases handled by name:
    // operands of magnitude 2^23 up to 2^24, whose sum is a tie, and the
    // largest value below one half, whose sum rounds up to one.
    function automatic logic [31:0] f_round_half(input logic [31:0] b);
        logic [7:0]  e;
        logic [4:0]  sh;
        logic [31:0] mask;
        logic [31:0] half;
        logic [31:0] frac;
        logic        inc;
        logic [31:0] r;
        e    = b[30:23];
        sh   = 5'd0;
        mask = 32'd0;
        half = 32'd0;
        frac = 32'd0;
        inc  = 1'b0;
        r    = b;
        if (e >= 8'd151) begin
            r = b;
        end else if (e == 8'd150) begin
            if (b[0]) begin
                r = b[31] ? (b - 32'd1) : (b + 32'd1);
            end
        end else if (e >= 8'd127) begin
            sh   = 5'(8'd150 - e);
            mask = (32'd1 << sh) - 32'd1;
            half = (mask + 32'd1) >> 1;
            frac = b & mask;
            inc  = b[31] ? (frac > half) : (frac >= half);
            r    = (inc ? (b + mask + 32'd1) : b) & ~mask;
        end else if (e == 8'd126) begin
            if (b[31]) begin
                r = (b[22:0] == 23'd0) ? ZERO_BITS : MONE_BITS;
            end else begin
                r = ONE_BITS;
            end
        end else begin
            r = (b == BELOW_HALF) ? ONE_BITS : ZERO_BITS;
        end
        return r;
    endfunction

    // -limit < x < limit in IEEE compare.
    function automatic logic f_near(input logic [31:0] b, input logic [31:0] eps);
        logic eps_pos;
        eps_pos = !eps[31] && (eps[30:0] != 31'd0) && !f_is_nan(eps);
        return eps_pos && !f_is_nan(b) && (b[30:0] < eps[30:0]);
    endfunction

    // Decode one lane: finish every operation but the reciprocal divide, and
    // set up the divider with a normalized 24-bit divisor.
    function automatic t_lane f_prep(input t_op op, input logic [31:0] b);
        t_lane      l;
        logic [7:0] e;
        logic [4:0] p;
        e         = b[30:23];
        p         = 5'd0;
        l.res     = b;
        l.use_res = 1'b1;
        l.sgn     = b[31];
        l.ex      = 10'sd0;
        l.m       = 24'd0;
        l.rem     = 24'h40_0000;
        l.q       = 27'd0;
        case (op)
            OP_ABS:    l.res = f_is_neg(b) ? (b ^ SIGN_BIT) : b;
            OP_CEIL:   l.res = f_round_int(b, 1'b1);
            OP_FLOOR:  l.res = f_round_int(b, 1'b0);
            OP_NEGATE: l.res = b ^ SIGN_BIT;
            OP_ROUND:  l.res = f_is_nan(b) ? (b | QUIET_BIT) : f_round_half(b);
            OP_RECIP: begin
                if (f_is_nan(b)) begin
                    l.res = b | QUIET_BIT;
                end else if (b[30:0] == 31'd0) begin
                    l.res = {b[31], INF_MAG};
                end else if (e == 8'hFF) begin
                    l.res = {b[31], 31'd0};
                end else begin
                    l.use_res = 1'b0;
                    if (e != 8'd0) begin
                        l.m  = {1'b1, b[22:0]};
                        l.ex = $signed({2'b00, e}) - 10'sd127;
                    end else begin
                        // Subnormal: bring the leading one up to bit 23.
                        for (int i = 0; i < 23; i++) begin
                            if (b[i]) begin
                                p = 5'(i);
                            end
                        end
                        l.m  = 24'({1'b0, b[22:0]} << (5'd23 - p));
                        l.ex = $signed({5'b00000, p}) - 10'sd149;
                    end
                end
            end
            default:   l.res = f_is_neg(b) ? MONE_BITS : ONE_BITS;
        endcase
        return l;
    endfunction

    // Three restoring division steps of floor(2^49 / m).
    function automatic t_lane f_div(input t_lane l_in);
        t_lane       l;
        logic [24:0] r2;
        l = l_in;
        for (int s = 0; s < DIV_STEPS; s++) begin
            r2 = {l.rem, 1'b0};
            if (r2 >= {1'b0, l.m}) begin
                l.rem = 24'(r2 - {1'b0, l.m});
                l.q   = {l.q[25:0], 1'b1};
            end else begin
                l.rem = r2[23:0];
                l.q   = {l.q[25:0], 1'b0};
            end
        end
        return l;
    endfunction

    // Round the quotient to nearest even and pack it, with gradual underflow
    // for huge divisors and overflow to infinity for tiny ones.
    function automatic logic [31:0] f_finish(input t_lane l);
        logic signed [10:0] eb;
        logic [23:0]        sig;
        logic               g;
        logic               st;
        logic [30:0]        base;
        logic               inc;
        logic [31:0]        r;
        sig  = l.q[25:2];
        g    = l.q[1];
        st   = l.q[0] | (l.rem != 24'd0);
        base = 31'd0;
        inc  = 1'b0;
        eb   = 11'sd0;
        r    = l.res;
        if (!l.use_res) begin
            if (l.q[26]) begin
                // Divisor mantissa of exactly one: the result is a power of two.
                eb = 11'sd127 - $signed({l.ex[9], l.ex});
                if (eb >= 11'sd255) begin
                    r = {l.sgn, INF_MAG};
                end else if (eb >= 11'sd1) begin
                    r = {l.sgn, eb[7:0], 23'd0};
                end else begin
                    r = {l.sgn, 8'd0, 23'h40_0000};
                end
            end else begin
                eb = 11'sd126 - $signed({l.ex[9], l.ex});
                if (eb >= 11'sd255) begin
                    base = INF_MAG;
                end else if (eb >= 11'sd1) begin
                    base = {eb[7:0], sig[22:0]};
                    inc  = g & (st | sig[0]);
                end else if (eb == 11'sd0) begin
                    base = {8'd0, sig[23:1]};
                    inc  = sig[0] & (g | st | sig[1]);
                end else begin
                    base = {8'd0, 1'b0, sig[23:2]};
                    inc  = sig[1] & (sig[0] | g | st | sig[2]);
                end
                r = {l.sgn, 31'(base + 31'(inc))};
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Pipeline control: a stage may load when it is empty or the stage after
    // it is loading in the same cycle.
    // ------------------------------------------------------------------------
    logic                  r_iv;
    t_in_item              r_in;
    logic [NUM_STAGES-1:0] r_pv;
    t_stage                r_pipe [NUM_STAGES];
    logic                  r_ov;
    t_out_item             r_out;

    logic                  w_rdy_out;
    logic [NUM_STAGES-1:0] w_rdy;
    logic                  w_rdy_in;
    t_stage                n_dec;
    t_out_item             n_out;

    always_comb begin
        w_rdy_out               = !r_ov || i_out_ready;
        w_rdy[NUM_STAGES-1]     = !r_pv[NUM_STAGES-1] || w_rdy_out;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_pv[k] || w_rdy[k+1];
        end
        w_rdy_in = !r_iv || w_rdy[0];
    end

    assign o_in_ready  = w_rdy_in;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Decode stage: the error decision is made here for the whole vector.
    always_comb begin
        n_dec.lane[0] = f_prep(r_op, r_in.in_x);
        n_dec.lane[1] = f_prep(r_op, r_in.in_y);
        n_dec.lane[2] = f_prep(r_op, r_in.in_z);
        n_dec.err     = (r_op == OP_INVALID) ||
                        ((r_op == OP_RECIP) &&
                         (f_near(r_in.in_x, r_limit) || f_near(r_in.in_y, r_limit) ||
                          f_near(r_in.in_z, r_limit)));
    end

    // Output stage: an error replaces the whole vector.
    always_comb begin
        if (r_pipe[NUM_STAGES-1].err) begin
            n_out.out_x = r_err_x;
            n_out.out_y = r_err_y;
            n_out.out_z = r_err_z;
        end else begin
            n_out.out_x = f_finish(r_pipe[NUM_STAGES-1].lane[0]);
            n_out.out_y = f_finish(r_pipe[NUM_STAGES-1].lane[1]);
            n_out.out_z = f_finish(r_pipe[NUM_STAGES-1].lane[2]);
        end
        n_out.error_flag    = r_pipe[NUM_STAGES-1].err;
        n_out.abort_request = r_pipe[NUM_STAGES-1].err && r_abort_en;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_pv <= '0;
            r_ov <= 1'b0;
        end else begin
            if (w_rdy_in) begin
                r_iv <= i_in_valid;
            end
            if (w_rdy[0]) begin
                r_pv[0] <= r_iv;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_pv[k] <= r_pv[k-1];
                end
            end
            if (w_rdy_out) begin
                r_ov <= r_pv[NUM_STAGES-1];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_rdy_in && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_rdy[0]) begin
            r_pipe[0] <= n_dec;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_rdy[k]) begin
                r_pipe[k].err     <= r_pipe[k-1].err;
                r_pipe[k].lane[0] <= f_div(r_pipe[k-1].lane[0]);
                r_pipe[k].lane[1] <= f_div(r_pipe[k-1].lane[1]);
                r_pipe[k].lane[2] <= f_div(r_pipe[k-1].lane[2]);
            end
        end
        if (w_rdy_out) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // An accepted item always lands in the input register.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_iv)
        else $error("accepted item did not reach the input register");

    // With every stage full and the output stalled, no item may be accepted.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready && r_iv && (&r_pv)) |-> !o_in_ready)
        else $error("item accepted into a full pipeline");

    // An abort request is only raised together with the error flag.
    a_abort_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.abort_request) |-> o_out_data.error_flag)
        else $error("abort request without error flag");

endmodule
